// ===== src/woyds_pkg.sv =====
package woyds_pkg;

   localparam logic [13:0] YEAR_MIN = 14'd1;
   localparam logic [13:0] YEAR_MAX = 14'd9999;
   localparam logic [5:0]  WEEK_MIN = 6'd1;
   localparam logic [5:0]  WEEK_MAX = 6'd53;

   // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x < 43699
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;
   // floor(x / 7) = (x * DIV7_MUL) >> DIV7_SHIFT for x < 16384
   localparam logic [15:0] DIV7_MUL     = 16'd37451;
   localparam int          DIV7_SHIFT   = 18;

   localparam logic [8:0] MONTH_START [12] = '{
      9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_MAR_IDX = 4'd2;

   typedef struct packed {
      logic [13:0] year;
      logic [5:0]  week_number;
   } req_type;

   typedef struct packed {
      logic [2:0]  start_weekday;
      logic [2:0]  end_weekday;
      logic [3:0]  start_month;
      logic [4:0]  start_day;
      logic [3:0]  end_month;
      logic [4:0]  end_day;
      logic [13:0] end_year_out;
   } rsp_type;

   typedef struct packed {
      logic [3:0] month;
      logic [4:0] day;
      logic       roll;
   } date_type;

   typedef struct packed {
      logic leap;
   } year_info_type;

   function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
      logic [8:0] base;
      base = MONTH_START[idx];
      if (leap && idx >= MONTH_MAR_IDX) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

// ===== src/week_of_year_date_span.sv =====
// A request taken at one edge has its result on the ports, with rsp_valid high for a
// single cycle, once it has passed the input register and stages A to D.
// Throughput: one request per cycle; busy is always low.
// Reset clears the stage valid bits only; requests in flight are dropped.
module week_of_year_date_span (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  woyds_pkg::req_type   req_item,
   output logic                 rsp_valid,
   output woyds_pkg::rsp_type   rsp_item
);

   localparam int STAGES = 5;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic              accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign valid_in = {valid_ff[STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // input stage: clamp
   logic [13:0] year_in;
   logic [5:0]  week_in;
   logic [13:0] year_ff;
   logic [13:0] year_prev_ff;
   logic [5:0]  week_ff;

   always_comb begin
      year_in = req_item.year;
      if (year_in < woyds_pkg::YEAR_MIN) begin
         year_in = woyds_pkg::YEAR_MIN;
      end else if (year_in > woyds_pkg::YEAR_MAX) begin
         year_in = woyds_pkg::YEAR_MAX;
      end
      week_in = req_item.week_number;
      if (week_in < woyds_pkg::WEEK_MIN) begin
         week_in = woyds_pkg::WEEK_MIN;
      end else if (week_in > woyds_pkg::WEEK_MAX) begin
         week_in = woyds_pkg::WEEK_MAX;
      end
   end

   always_ff @(posedge clock) begin
      year_ff      <= year_in;
      year_prev_ff <= year_in - 14'd1;
      week_ff      <= week_in;
   end

   woyds_pkg::year_info_type info;

   woyds_year u_year (
      .clock         (clock),
      .year          (year_ff),
      .year_prev     (year_prev_ff),
      .info          (info),
      .start_weekday (rsp_item.start_weekday),
      .end_weekday   (rsp_item.end_weekday)
   );

   woyds_date u_date (
      .clock        (clock),
      .year         (year_ff),
      .week_number  (week_ff),
      .info         (info),
      .start_month  (rsp_item.start_month),
      .start_day    (rsp_item.start_day),
      .end_month    (rsp_item.end_month),
      .end_day      (rsp_item.end_day),
      .end_year_out (rsp_item.end_year_out)
   );

   assign rsp_valid = valid_ff[STAGES-1];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("request did not produce a result after five cycles");

   a_weekday_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.start_weekday < 3'd7) &&
         (((rsp_item.start_weekday == 3'd0) && (rsp_item.end_weekday == 3'd6)) ||
          (rsp_item.end_weekday + 3'd1 == rsp_item.start_weekday)))
      else $error("end weekday does not precede start weekday");

   a_rollover: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.start_month == 4'd12) && (rsp_item.end_month == 4'd1)
      |-> (rsp_item.end_year_out != 14'd1) && (rsp_item.end_day < 5'd7))
      else $error("year rollover result out of range");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.start_month >= 4'd1) && (rsp_item.start_month <= 4'd12) &&
         (rsp_item.end_month >= 4'd1) && (rsp_item.end_month <= 4'd12))
      else $error("month out of range");

endmodule

// ===== src/woyds_year.sv =====
module woyds_year (
   input  logic                        clock,
   input  logic [13:0]                 year,
   input  logic [13:0]                 year_prev,
   output woyds_pkg::year_info_type    info,
   output logic [2:0]                  start_weekday,
   output logic [2:0]                  end_weekday
);

   // stage A: centuries of y and y-1
   logic [26:0] prod_prev_in;
   logic [26:0] prod_year_in;
   logic [7:0]  cent_prev_ff;
   logic [7:0]  cent_year_ff;
   logic [13:0] year_a_ff;
   logic [13:0] prev_a_ff;

   assign prod_prev_in = 27'(year_prev) * 27'(woyds_pkg::DIV100_MUL);
   assign prod_year_in = 27'(year) * 27'(woyds_pkg::DIV100_MUL);

   always_ff @(posedge clock) begin
      cent_prev_ff <= prod_prev_in[woyds_pkg::DIV100_SHIFT +: 8];
      cent_year_ff <= prod_year_in[woyds_pkg::DIV100_SHIFT +: 8];
      year_a_ff    <= year;
      prev_a_ff    <= year_prev;
   end

   // stage B: day count mod-7 operand and leap flag
   logic [14:0] sum_in;
   logic [13:0] hund_in;
   logic [13:0] rem_in;
   logic        leap_in;
   logic [13:0] sum_ff;
   logic        leap_ff;

   assign sum_in = 15'(prev_a_ff) + 15'(prev_a_ff[13:2]) - 15'(cent_prev_ff)
                 + 15'(cent_prev_ff[7:2]) + 15'd1;
   assign hund_in = (14'(cent_year_ff) << 6) + (14'(cent_year_ff) << 5)
                  + (14'(cent_year_ff) << 2);
   assign rem_in  = year_a_ff - hund_in;
   assign leap_in = ((year_a_ff[1:0] == 2'd0) && (rem_in != 14'd0))
                 || ((rem_in == 14'd0) && (cent_year_ff[1:0] == 2'd0));

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in[13:0];
      leap_ff <= leap_in;
   end

   assign info.leap = leap_ff;

   // stage C: quotient by 7
   logic [29:0] prod7_in;
   logic [11:0] q7_ff;
   logic [13:0] sum_c_ff;

   assign prod7_in = 30'(sum_ff) * 30'(woyds_pkg::DIV7_MUL);

   always_ff @(posedge clock) begin
      q7_ff    <= prod7_in[woyds_pkg::DIV7_SHIFT +: 12];
      sum_c_ff <= sum_ff;
   end

   // stage D: remainder and end weekday
   logic [13:0] rem7_in;
   logic [2:0]  wd_start_in;
   logic [2:0]  wd_end_in;
   logic [2:0]  wd_start_ff;
   logic [2:0]  wd_end_ff;

   assign rem7_in     = sum_c_ff - ((14'(q7_ff) << 3) - 14'(q7_ff));
   assign wd_start_in = rem7_in[2:0];
   assign wd_end_in   = (wd_start_in == 3'd0) ? 3'd6 : wd_start_in - 3'd1;

   always_ff @(posedge clock) begin
      wd_start_ff <= wd_start_in;
      wd_end_ff   <= wd_end_in;
   end

   assign start_weekday = wd_start_ff;
   assign end_weekday   = wd_end_ff;

endmodule

// ===== src/woyds_date.sv =====
module woyds_date (
   input  logic                        clock,
   input  logic [13:0]                 year,
   input  logic [5:0]                  week_number,
   input  woyds_pkg::year_info_type    info,
   output logic [3:0]                  start_month,
   output logic [4:0]                  start_day,
   output logic [3:0]                  end_month,
   output logic [4:0]                  end_day,
   output logic [13:0]                 end_year_out
);

   function automatic woyds_pkg::date_type to_date(input logic [8:0] doy, input logic leap);
      logic [8:0]          ylen;
      logic [3:0]          idx;
      logic [8:0]          base;
      woyds_pkg::date_type d;
      ylen = leap ? 9'd366 : 9'd365;
      idx  = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (doy > woyds_pkg::month_start(4'(m), leap)) begin
            idx = 4'(m);
         end
      end
      base    = woyds_pkg::month_start(idx, leap);
      d.month = idx + 4'd1;
      d.day   = 5'(doy - base);
      d.roll  = 1'b0;
      if (doy > ylen) begin
         d.month = woyds_pkg::MONTH_JAN;
         d.day   = 5'(doy - ylen);
         d.roll  = 1'b1;
      end
      return d;
   endfunction

   // stage A: day-of-year bounds
   logic [8:0]  doy_end_in;
   logic [8:0]  doy_start_a_ff;
   logic [8:0]  doy_end_a_ff;
   logic [13:0] year_a_ff;

   assign doy_end_in = (9'(week_number) << 3) - 9'(week_number);

   always_ff @(posedge clock) begin
      doy_start_a_ff <= doy_end_in - 9'd6;
      doy_end_a_ff   <= doy_end_in;
      year_a_ff      <= year;
   end

   // stage B: wait for leap flag
   logic [8:0]  doy_start_b_ff;
   logic [8:0]  doy_end_b_ff;
   logic [13:0] year_b_ff;

   always_ff @(posedge clock) begin
      doy_start_b_ff <= doy_start_a_ff;
      doy_end_b_ff   <= doy_end_a_ff;
      year_b_ff      <= year_a_ff;
   end

   // stage C: month lookup
   woyds_pkg::date_type start_in;
   woyds_pkg::date_type end_in;
   woyds_pkg::date_type start_c_ff;
   woyds_pkg::date_type end_c_ff;
   logic [13:0]         year_c_ff;

   assign start_in = to_date(doy_start_b_ff, info.leap);
   assign end_in   = to_date(doy_end_b_ff, info.leap);

   always_ff @(posedge clock) begin
      start_c_ff <= start_in;
      end_c_ff   <= end_in;
      year_c_ff  <= year_b_ff;
   end

   // stage D: year of last day
   logic [3:0]  start_month_ff;
   logic [4:0]  start_day_ff;
   logic [3:0]  end_month_ff;
   logic [4:0]  end_day_ff;
   logic [13:0] end_year_in;
   logic [13:0] end_year_ff;

   assign end_year_in = end_c_ff.roll ? year_c_ff + 14'd1 : year_c_ff;

   always_ff @(posedge clock) begin
      start_month_ff <= start_c_ff.month;
      start_day_ff   <= start_c_ff.day;
      end_month_ff   <= end_c_ff.month;
      end_day_ff     <= end_c_ff.day;
      end_year_ff    <= end_year_in;
   end

   assign start_month  = start_month_ff;
   assign start_day    = start_day_ff;
   assign end_month    = end_month_ff;
   assign end_day      = end_day_ff;
   assign end_year_out = end_year_ff;

endmodule
